### design/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and helpers for the picture clause classifier.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // running counts saturate at the top of this width
  localparam int COUNT_BITS   = 16;
  localparam int LONG_BYTES   = 8;
  localparam int DOUBLE_BYTES = 8;
  // width of the count fields on the result channel
  localparam int OUT_W        = 16;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [OUT_W-1:0]      out_t;

  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  // picture kinds
  typedef enum logic [1:0] {
    KIND_UNDEF   = 2'd0,
    KIND_STRING  = 2'd1,
    KIND_INTEGER = 2'd2,
    KIND_FLOAT   = 2'd3
  } kind_e;

  // picture characters
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // one picture character handed to the classifier core
  typedef struct packed {
    logic       valid;
    logic [7:0] pic_char;
    logic       last;
  } step_t;

  // one classification result
  typedef struct packed {
    kind_e kind;
    logic  error;
    out_t  subst_size;
    out_t  storage_size;
    out_t  digits_before;
    out_t  digits_after;
    out_t  filler_zeroes;
    logic  trailing_sign;
    out_t  expanded_length;
  } result_t;

  // saturating add of two counts
  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // count to result field width
  function automatic out_t to_out(cnt_t c);
    return OUT_W'(c);
  endfunction

endpackage

### design/pcc_core.sv
// ----------------------------------------------------------------------------
// pcc_core
// Running picture state: repeat counts, character counters and kind. Forms
// the result combinationally on the final character and clears for the next.
// ----------------------------------------------------------------------------
module pcc_core import pcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  step_t   step_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [7:0] prev_char_q, prev_char_d;
  logic       prev_added_q, prev_added_d;
  logic       in_count_q, in_count_d;
  cnt_t       repeat_acc_q, repeat_acc_d;
  cnt_t       size_q, size_d;
  cnt_t       length_q, length_d;
  cnt_t       before_q, before_d;
  cnt_t       after_q, after_d;
  cnt_t       filler_q, filler_d;
  logic       after_point_q, after_point_d;
  kind_e      kind_q, kind_d;
  logic       sign_q, sign_d;

  logic [7:0]            c;
  logic                  is_digit;
  logic [COUNT_BITS+3:0] acc_wide;
  cnt_t                  acc_digit;
  logic [7:0]            eff_char;
  cnt_t                  eff_m;
  cnt_t                  storage;

  assign c        = step_i.pic_char;
  assign is_digit = (c >= CH_0) && (c <= CH_9);

  // repeat count times ten plus the new digit, saturated
  assign acc_wide  = ({4'b0, repeat_acc_q} << 3) + ({4'b0, repeat_acc_q} << 1)
                   + (COUNT_BITS + 4)'(c[3:0]);
  assign acc_digit = (|acc_wide[COUNT_BITS+3:COUNT_BITS]) ? CNT_MAX
                                                          : acc_wide[COUNT_BITS-1:0];

  // copies still owed by a count when the previous character is already in
  function automatic cnt_t owed(cnt_t n, logic added);
    if (added) begin
      return (n == '0) ? '0 : n - cnt_t'(1);
    end
    return n;
  endfunction

  // next state and result
  always_comb begin
    prev_char_d   = prev_char_q;
    prev_added_d  = prev_added_q;
    in_count_d    = in_count_q;
    repeat_acc_d  = repeat_acc_q;
    size_d        = size_q;
    length_d      = length_q;
    before_d      = before_q;
    after_d       = after_q;
    filler_d      = filler_q;
    after_point_d = after_point_q;
    kind_d        = kind_q;
    sign_d        = sign_q;
    eff_char      = c;
    eff_m         = '0;
    storage       = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (step_i.valid) begin
      // pick the character to add and its multiplicity
      if (in_count_q) begin
        if (is_digit) begin
          repeat_acc_d = acc_digit;
          if (step_i.last) begin
            eff_char = prev_char_q;
            eff_m    = owed(acc_digit, prev_added_q);
          end
        end else begin
          eff_char     = prev_char_q;
          eff_m        = owed(repeat_acc_q, prev_added_q);
          prev_char_d  = c;
          prev_added_d = 1'b0;
          in_count_d   = 1'b0;
          repeat_acc_d = '0;
        end
      end else if (c == CH_OPEN) begin
        in_count_d   = 1'b1;
        repeat_acc_d = '0;
      end else if (c == CH_CLOSE) begin
        prev_char_d  = c;
        prev_added_d = 1'b0;
      end else begin
        eff_m        = cnt_t'(1);
        prev_char_d  = c;
        prev_added_d = 1'b1;
      end

      // character effects
      if (eff_m != '0) begin
        length_d = sat_add(length_q, eff_m);
        if (!(eff_char == CH_DOT || eff_char == CH_COMMA || eff_char == CH_SLASH ||
              eff_char == CH_B || eff_char == CH_0)) begin
          size_d = sat_add(size_q, eff_m);
        end
        priority if (eff_char == CH_X || eff_char == CH_A) begin
          kind_d = KIND_STRING;
        end else if (eff_char == CH_9 || eff_char == CH_0 || eff_char == CH_Z ||
                     eff_char == CH_STAR) begin
          if (kind_q == KIND_UNDEF) begin
            kind_d = KIND_INTEGER;
          end
          if (after_point_q) begin
            after_d = sat_add(after_q, eff_m);
          end else begin
            before_d = sat_add(before_q, eff_m);
          end
        end else if (eff_char == CH_S) begin
          sign_d = 1'b1;
        end else if (eff_char == CH_P) begin
          filler_d = sat_add(filler_q, eff_m);
        end else if (eff_char == CH_V) begin
          kind_d        = KIND_FLOAT;
          after_point_d = 1'b1;
        end else begin
          kind_d = kind_q;
        end
      end

      // result on the final character, then clear for the next picture
      if (step_i.last) begin
        unique case (kind_d)
          KIND_STRING:  storage = sat_add(size_d, cnt_t'(1));
          KIND_INTEGER: storage = cnt_t'(LONG_BYTES);
          KIND_FLOAT:   storage = cnt_t'(DOUBLE_BYTES);
          default:      storage = '0;
        endcase
        res_valid_o           = 1'b1;
        res_o.kind            = kind_d;
        res_o.error           = (kind_d == KIND_UNDEF);
        res_o.subst_size      = to_out(size_d);
        res_o.storage_size    = to_out(storage);
        res_o.digits_before   = to_out(before_d);
        res_o.digits_after    = to_out(after_d);
        res_o.filler_zeroes   = to_out(filler_d);
        res_o.trailing_sign   = sign_d;
        res_o.expanded_length = to_out(length_d);

        prev_char_d   = CH_X;
        prev_added_d  = 1'b0;
        in_count_d    = 1'b0;
        repeat_acc_d  = '0;
        size_d        = '0;
        length_d      = '0;
        before_d      = '0;
        after_d       = '0;
        filler_d      = '0;
        after_point_d = 1'b0;
        kind_d        = KIND_UNDEF;
        sign_d        = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_char_q   <= CH_X;
      prev_added_q  <= 1'b0;
      in_count_q    <= 1'b0;
      repeat_acc_q  <= '0;
      size_q        <= '0;
      length_q      <= '0;
      before_q      <= '0;
      after_q       <= '0;
      filler_q      <= '0;
      after_point_q <= 1'b0;
      kind_q        <= KIND_UNDEF;
      sign_q        <= 1'b0;
    end else begin
      prev_char_q   <= prev_char_d;
      prev_added_q  <= prev_added_d;
      in_count_q    <= in_count_d;
      repeat_acc_q  <= repeat_acc_d;
      size_q        <= size_d;
      length_q      <= length_d;
      before_q      <= before_d;
      after_q       <= after_d;
      filler_q      <= filler_d;
      after_point_q <= after_point_d;
      kind_q        <= kind_d;
      sign_q        <= sign_d;
    end
  end

endmodule

### design/picture_clause_classifier_top.sv
// ----------------------------------------------------------------------------
// picture_clause_classifier_top
// Classifies a picture-format string fed one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one picture character and
//   a last flag per transaction. A count in parentheses repeats the previous
//   character. Output channel (out_valid_o / out_ready_i) carries one result
//   transaction per picture, formed on the character marked last.
//   A character is registered at the input, processed combinationally by
//   the core, and its result is registered at the output (out_valid_o).
//   Throughput: one character per cycle unless the receiver stalls; the
//   core updates its state once per accepted character.
//   Reset clears all picture state (previous character back to x) and empties
//   both registers. When the receiver stalls, the held result blocks the core
//   and in_ready_o drops as soon as a character waits in the input register;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module picture_clause_classifier_top import pcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pic_char_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        error_o,
  output logic [15:0] subst_size_o,
  output logic [15:0] storage_size_o,
  output logic [15:0] digits_before_o,
  output logic [15:0] digits_after_o,
  output logic [15:0] filler_zeroes_o,
  output logic        trailing_sign_o,
  output logic [15:0] expanded_length_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_valid_q;
  result_t    res_q;
  logic       advance;
  step_t      step;
  logic       res_valid;
  result_t    res;

  // core moves when the result register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign step.valid    = in_valid_q && advance;
  assign step.pic_char = char_q;
  assign step.last     = last_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= pic_char_i;
      last_q <= last_i;
    end
  end

  pcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign error_o           = res_q.error;
  assign subst_size_o      = res_q.subst_size;
  assign storage_size_o    = res_q.storage_size;
  assign digits_before_o   = res_q.digits_before;
  assign digits_after_o    = res_q.digits_after;
  assign filler_zeroes_o   = res_q.filler_zeroes;
  assign trailing_sign_o   = res_q.trailing_sign;
  assign expanded_length_o = res_q.expanded_length;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the picture clause classifier. Pictures go in one
// character per transaction; a cycle-free predictor tracks repeat counts and
// running totals and forms the expected classification on each last
// character. A short directed table comes first, then random pictures built
// from picture characters and well-formed repeat counts mixed with stray bytes and broken counts.
// ----------------------------------------------------------------------------
module tb import pcc_pkg::*; ();

  localparam int ITEM_TARGET = 450;
  localparam int STALL_LIMIT = 1000;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    result_t    want;
  } row_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  pic_char_i      = '0;
  logic        last_i          = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [1:0]  kind_o;
  logic        error_o;
  logic [15:0] subst_size_o;
  logic [15:0] storage_size_o;
  logic [15:0] digits_before_o;
  logic [15:0] digits_after_o;
  logic [15:0] filler_zeroes_o;
  logic        trailing_sign_o;
  logic [15:0] expanded_length_o;

  picture_clause_classifier_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pic_char_i       (pic_char_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .error_o          (error_o),
    .subst_size_o     (subst_size_o),
    .storage_size_o   (storage_size_o),
    .digits_before_o  (digits_before_o),
    .digits_after_o   (digits_after_o),
    .filler_zeroes_o  (filler_zeroes_o),
    .trailing_sign_o  (trailing_sign_o),
    .expanded_length_o(expanded_length_o)
  );

  // classification state of the picture in flight
  logic [7:0]  last_sym;
  logic        last_sym_counted;
  logic        count_open;
  int unsigned rep_value;
  cnt_t        n_subst, n_len, n_before, n_after, n_fill;
  logic        point_seen;
  kind_e       cur_kind;
  logic        sign_flag;

  result_t     expect_q[$];
  row_t        dir_rows[$];
  logic [7:0]  pic_buf[$];
  logic [7:0]  alphabet [13] = '{CH_X, CH_A, CH_9, CH_0, CH_Z, CH_STAR, CH_S, CH_P,
                                 CH_V, CH_B, CH_DOT, CH_COMMA, CH_SLASH};
  int          sent_items   = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  int          stall_cycles = 0;
  int          pictures     = 0;
  wire         calm = (sent_items >= 200) && (sent_items < 300);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // saturating add on a running count
  function automatic cnt_t grow(cnt_t a, int unsigned m);
    int unsigned s;
    s = a + m;
    return (s > CNT_MAX) ? CNT_MAX : cnt_t'(s);
  endfunction

  // put m copies of one character into the expansion
  function automatic void place_sym(logic [7:0] c, int unsigned m);
    if (m == 0) return;
    n_len = grow(n_len, m);
    if (!(c inside {CH_DOT, CH_COMMA, CH_SLASH, CH_B, CH_0})) n_subst = grow(n_subst, m);
    case (c)
      CH_X, CH_A: cur_kind = KIND_STRING;
      CH_9, CH_0, CH_Z, CH_STAR: begin
        if (cur_kind == KIND_UNDEF) cur_kind = KIND_INTEGER;
        if (point_seen) n_after = grow(n_after, m);
        else n_before = grow(n_before, m);
      end
      CH_S: sign_flag = 1'b1;
      CH_P: n_fill = grow(n_fill, m);
      CH_V: begin
        cur_kind   = KIND_FLOAT;
        point_seen = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // close a repeat count: n copies in all of the previous character
  function automatic void close_count();
    int unsigned m;
    m = rep_value;
    if (last_sym_counted) m = (m > 0) ? m - 1 : 0;
    place_sym(last_sym, m);
    count_open = 1'b0;
    rep_value  = 0;
  endfunction

  function automatic void clear_picture();
    last_sym         = CH_X;
    last_sym_counted = 1'b0;
    count_open       = 1'b0;
    rep_value        = 0;
    n_subst          = '0;
    n_len            = '0;
    n_before         = '0;
    n_after          = '0;
    n_fill           = '0;
    point_seen       = 1'b0;
    cur_kind         = KIND_UNDEF;
    sign_flag        = 1'b0;
  endfunction

  // advance the classification by one character
  function automatic void classify_char(input logic [7:0] c, input logic fin,
                                        output logic has_res, output result_t res);
    res = '0;
    if (count_open) begin
      if (c >= CH_0 && c <= CH_9) begin
        rep_value = rep_value * 10 + (c - CH_0);
        if (rep_value > CNT_MAX) rep_value = CNT_MAX;
      end else begin
        close_count();
        last_sym         = c;
        last_sym_counted = 1'b0;
      end
    end else if (c == CH_OPEN) begin
      count_open = 1'b1;
      rep_value  = 0;
    end else if (c == CH_CLOSE) begin
      last_sym         = c;
      last_sym_counted = 1'b0;
    end else begin
      place_sym(c, 1);
      last_sym         = c;
      last_sym_counted = 1'b1;
    end
    has_res = fin;
    if (fin) begin
      if (count_open) close_count();
      res.kind  = cur_kind;
      res.error = (cur_kind == KIND_UNDEF);
      case (cur_kind)
        KIND_STRING:  res.storage_size = grow(n_subst, 1);
        KIND_INTEGER: res.storage_size = out_t'(LONG_BYTES);
        KIND_FLOAT:   res.storage_size = out_t'(DOUBLE_BYTES);
        default:      res.storage_size = '0;
      endcase
      res.subst_size      = n_subst;
      res.digits_before   = n_before;
      res.digits_after    = n_after;
      res.filler_zeroes   = n_fill;
      res.trailing_sign   = sign_flag;
      res.expanded_length = n_len;
      clear_picture();
    end
  endfunction

  function automatic result_t make_result(kind_e k, logic e, int sub, int sto, int bef,
                                          int aft, int fil, logic sgn, int len);
    result_t r;
    r.kind            = k;
    r.error           = e;
    r.subst_size      = out_t'(sub);
    r.storage_size    = out_t'(sto);
    r.digits_before   = out_t'(bef);
    r.digits_after    = out_t'(aft);
    r.filler_zeroes   = out_t'(fil);
    r.trailing_sign   = sgn;
    r.expanded_length = out_t'(len);
    return r;
  endfunction

  function automatic row_t mk_row(logic [7:0] c, logic fin, logic typed, result_t want);
    row_t r;
    r.ch    = c;
    r.fin   = fin;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic void note_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endfunction

  // drive one character transaction, starting at a falling edge
  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input result_t want);
    logic    has_res;
    result_t res;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      pic_char_i <= 8'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pic_char_i <= c;
    last_i     <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
    classify_char(c, fin, has_res, res);
    if (has_res) begin
      expect_q.push_back(typed ? want : res);
      pictures++;
    end
    @(negedge clk_i);
  endtask

  // hold the sender off until every pending result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expect_q.size() != 0);
  endtask

  // random picture: mostly characters and repeat counts, some noise
  task automatic build_picture();
    int unsigned pick, n;
    string       digits;
    pic_buf.delete();
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pic_buf.push_back(alphabet[$urandom_range(0, 12)]);
      end else if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) n = $urandom_range(0, 5);
        else if (pick < 95) n = $urandom_range(6, 300);
        else n = $urandom_range(1000, 99999);
        digits = $sformatf("%0d", n);
        pic_buf.push_back(CH_OPEN);
        for (int i = 0; i < digits.len(); i++) pic_buf.push_back(digits[i]);
        // sometimes the next character closes the count instead
        if ($urandom_range(0, 9) != 0) pic_buf.push_back(CH_CLOSE);
      end else if (pick < 88) begin
        pic_buf.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        pic_buf.push_back(CH_CLOSE);
      end else begin
        pic_buf.push_back(CH_OPEN);
      end
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 20);
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
      end else begin
        want = expect_q.pop_front();
        note_field("kind", want.kind, kind_o);
        note_field("error", want.error, error_o);
        note_field("subst_size", want.subst_size, subst_size_o);
        note_field("storage_size", want.storage_size, storage_size_o);
        note_field("digits_before", want.digits_before, digits_before_o);
        note_field("digits_after", want.digits_after, digits_after_o);
        note_field("filler_zeroes", want.filler_zeroes, filler_zeroes_o);
        note_field("trailing_sign", want.trailing_sign, trailing_sign_o);
        note_field("expanded_length", want.expanded_length, expanded_length_o);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    clear_picture();

    // lone open paren, then extreme single characters
    dir_rows.push_back(mk_row(CH_OPEN, 1'b1, 1'b1,
                              make_result(KIND_UNDEF, 1'b1, 0, 0, 0, 0, 0, 1'b0, 0)));
    dir_rows.push_back(mk_row(CH_A, 1'b1, 1'b1,
                              make_result(KIND_STRING, 1'b0, 1, 2, 0, 0, 0, 1'b0, 1)));
    dir_rows.push_back(mk_row(8'hFF, 1'b1, 1'b1,
                              make_result(KIND_UNDEF, 1'b1, 1, 0, 0, 0, 0, 1'b0, 1)));
    dir_rows.push_back(mk_row(8'h00, 1'b1, 1'b1,
                              make_result(KIND_UNDEF, 1'b1, 1, 0, 0, 0, 0, 1'b0, 1)));
    // saturating count left open on the last character
    dir_rows.push_back(mk_row(CH_9, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_OPEN, 1'b0, 1'b0, '0));
    repeat (4) dir_rows.push_back(mk_row(CH_9, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_9, 1'b1, 1'b1,
                              make_result(KIND_INTEGER, 1'b0, 65535, 8, 65535, 0, 0, 1'b0,
                                          65535)));
    // stray close, sign, zero count, point and every separator
    dir_rows.push_back(mk_row(CH_CLOSE, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_S, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_P, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_OPEN, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_0, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_CLOSE, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_V, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_Z, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_STAR, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_DOT, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_COMMA, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_SLASH, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_B, 1'b0, 1'b0, '0));
    dir_rows.push_back(mk_row(CH_0, 1'b1, 1'b0, '0));

    // reset
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed,
                                    dir_rows[i].want);
    drain_results();

    // random pictures
    while (sent_items < ITEM_TARGET) begin
      build_picture();
      for (int i = 0; i < pic_buf.size(); i++)
        send_char(pic_buf[i], i == pic_buf.size() - 1, 1'b0, '0);
      if (sent_items >= 350 && sent_items < 370) drain_results();
    end

    drain_results();
    repeat (4) @(negedge clk_i);

    $display("sent %0d characters in %0d pictures: extremes, repeat counts up to saturation,",
             sent_items, pictures);
    $display("stray and open counts, noise bytes; %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/pcc_pkg.sv
design/pcc_core.sv
design/picture_clause_classifier_top.sv
sim/tb.sv
